// ----- rtl/fbg_pkg.sv -----
// Shared types and constants for the fetch block grouper.
package fbg_pkg;

    localparam int ID_W = 6;
    localparam int OFS_W = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_BRANCH = 2'd1;
    localparam logic [1:0] KIND_JAL    = 2'd2;
    localparam logic [1:0] KIND_JALR   = 2'd3;

    localparam logic [1:0] OP_FULL = 2'b11;
    localparam logic [1:0] OP_C1   = 2'b01;
    localparam logic [1:0] OP_C2   = 2'b10;

    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;

    localparam logic [2:0] F3_CJ    = 3'b101;
    localparam logic [2:0] F3_CBEQZ = 3'b110;
    localparam logic [2:0] F3_CBNEZ = 3'b111;
    localparam logic [2:0] F3_CJR   = 3'b100;
    localparam logic [2:0] F3_JALR  = 3'b000;

    localparam logic [4:0] REG_RA = 5'd1;
    localparam logic [4:0] REG_T0 = 5'd5;

    typedef struct packed {
        logic [31:0] pc;
        logic        compressed;
        logic [1:0]  branch_kind;
        logic        call_flag;
        logic        return_flag;
        logic        predicted_taken;
        logic        next_compressed;
        logic        discontinuous;
    } t_pre;

endpackage

// ----- rtl/fbg_if.sv -----
// Input and result channel interfaces of the fetch block grouper.
interface fbg_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_pc;
    logic [31:0] instr_word;
    logic [31:0] following_pc;
    logic [1:0]  following_low_bits;
    logic        discontinuous;

    modport source (
        output valid, instr_pc, instr_word, following_pc, following_low_bits, discontinuous,
        input  ready
    );
    modport sink (
        input  valid, instr_pc, instr_word, following_pc, following_low_bits, discontinuous,
        output ready
    );
endinterface

interface fbg_out_if;
    logic       valid;
    logic       ready;
    logic       compressed;
    logic [1:0] branch_kind;
    logic       call_flag;
    logic       return_flag;
    logic       predicted_taken;
    logic       last_in_block;
    logic [5:0] block_id;
    logic       block_wrap;
    logic [4:0] halfword_offset;
    logic       block_started;

    modport source (
        output valid, compressed, branch_kind, call_flag, return_flag, predicted_taken,
               last_in_block, block_id, block_wrap, halfword_offset, block_started,
        input  ready
    );
    modport sink (
        input  valid, compressed, branch_kind, call_flag, return_flag, predicted_taken,
               last_in_block, block_id, block_wrap, halfword_offset, block_started,
        output ready
    );
endinterface

// ----- rtl/fbg_front.sv -----
// Front end: predecode of one instruction and redirect detection.
module fbg_front (
    input  logic          i_valid,
    input  logic [31:0]   i_instr_pc,
    input  logic [31:0]   i_instr_word,
    input  logic [31:0]   i_following_pc,
    input  logic [1:0]    i_following_low_bits,
    input  logic          i_discontinuous,
    input  logic          i_queue_full,
    output logic          o_ready,
    output logic          o_push,
    output fbg_pkg::t_pre o_pre
);

    logic [1:0]  w_op;
    logic [2:0]  w_c_f3;
    logic [4:0]  w_c_rs1;
    logic [6:0]  w_opc;
    logic [2:0]  w_f3;
    logic [4:0]  w_rd;
    logic [4:0]  w_rs1;
    logic        w_rvc;
    logic [1:0]  w_kind;
    logic [4:0]  w_link_rd;
    logic [4:0]  w_link_rs1;
    logic        w_call;
    logic [31:0] w_seq_pc;

    assign w_op    = i_instr_word[1:0];
    assign w_c_f3  = i_instr_word[15:13];
    assign w_c_rs1 = i_instr_word[11:7];
    assign w_opc   = i_instr_word[6:0];
    assign w_f3    = i_instr_word[14:12];
    assign w_rd    = i_instr_word[11:7];
    assign w_rs1   = i_instr_word[19:15];
    assign w_rvc   = (w_op != fbg_pkg::OP_FULL);

    always_comb begin
        w_kind     = fbg_pkg::KIND_NONE;
        w_link_rd  = 5'd0;
        w_link_rs1 = w_rs1;
        if (w_rvc) begin
            w_link_rs1 = w_c_rs1;
            if (w_op == fbg_pkg::OP_C1) begin
                if (w_c_f3 == fbg_pkg::F3_CJ) begin
                    w_kind = fbg_pkg::KIND_JAL;
                end else if (w_c_f3 == fbg_pkg::F3_CBEQZ || w_c_f3 == fbg_pkg::F3_CBNEZ) begin
                    w_kind = fbg_pkg::KIND_BRANCH;
                end
            end else if (w_op == fbg_pkg::OP_C2) begin
                if (w_c_f3 == fbg_pkg::F3_CJR && i_instr_word[6:2] == 5'd0
                        && w_c_rs1 != 5'd0) begin
                    w_kind    = fbg_pkg::KIND_JALR;
                    w_link_rd = i_instr_word[12] ? fbg_pkg::REG_RA : 5'd0;
                end
            end
        end else begin
            w_link_rd = w_rd;
            if (w_opc == fbg_pkg::OPC_BRANCH) begin
                w_kind = fbg_pkg::KIND_BRANCH;
            end else if (w_opc == fbg_pkg::OPC_JAL) begin
                w_kind = fbg_pkg::KIND_JAL;
            end else if (w_opc == fbg_pkg::OPC_JALR && w_f3 == fbg_pkg::F3_JALR) begin
                w_kind = fbg_pkg::KIND_JALR;
            end
        end
    end

    assign w_call = (((w_kind == fbg_pkg::KIND_JAL) && !w_rvc) || (w_kind == fbg_pkg::KIND_JALR))
                    && (w_link_rd == fbg_pkg::REG_RA || w_link_rd == fbg_pkg::REG_T0);

    assign w_seq_pc = i_instr_pc + (w_rvc ? 32'd2 : 32'd4);

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    always_comb begin
        o_pre.pc              = i_instr_pc;
        o_pre.compressed      = w_rvc;
        o_pre.branch_kind     = w_kind;
        o_pre.call_flag       = w_call;
        o_pre.return_flag     = (w_kind == fbg_pkg::KIND_JALR) && !w_call
                                && (w_link_rs1 == fbg_pkg::REG_RA
                                    || w_link_rs1 == fbg_pkg::REG_T0);
        o_pre.predicted_taken = (i_following_pc != w_seq_pc);
        o_pre.next_compressed = (i_following_low_bits != fbg_pkg::OP_FULL);
        o_pre.discontinuous   = i_discontinuous;
    end

endmodule

// ----- rtl/fbg_queue.sv -----
// Short FIFO of predecoded instructions between front and back end.
module fbg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fbg_pkg::t_pre i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output fbg_pkg::t_pre o_data
);

    fbg_pkg::t_pre                    r_mem [fbg_pkg::QUEUE_DEPTH];
    logic [fbg_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [fbg_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [fbg_pkg::QCNT_W-1:0]       r_count;
    logic [fbg_pkg::QCNT_W-1:0]       n_count;
    logic                             w_pop;

    assign o_full  = (r_count == fbg_pkg::QCNT_W'(fbg_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

// ----- rtl/fbg_back.sv -----
// Back end: fetch block grouping state and registered result stage.
module fbg_back #(
    parameter int BLOCK_BYTES      = 32,
    parameter int MAX_BLOCK_INSTRS = 16,
    parameter int ID_COUNT         = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  fbg_pkg::t_pre i_pre,
    output logic          o_pop,
    fbg_out_if.source     o_out
);

    localparam int BW = $clog2(BLOCK_BYTES + 1);
    localparam int SW = BW + 2;
    localparam int IW = $clog2(MAX_BLOCK_INSTRS + 1);
    localparam logic [SW-1:0] LIMIT_BYTES = SW'(BLOCK_BYTES);
    localparam logic [IW-1:0] LIMIT_INSTRS = IW'(MAX_BLOCK_INSTRS);
    localparam logic [fbg_pkg::ID_W-1:0] LAST_ID = fbg_pkg::ID_W'(ID_COUNT - 1);

    logic                       r_have_block;
    logic                       r_force_new;
    logic [fbg_pkg::ID_W-1:0]   r_block_id;
    logic                       r_wrap;
    logic [BW-1:0]              r_bytes;
    logic [IW-1:0]              r_instrs;
    logic [31:0]                r_start_pc;

    logic [fbg_pkg::ID_W-1:0]   n_block_id;
    logic                       n_wrap;

    logic                       r_out_valid;
    logic                       r_compressed;
    logic [1:0]                 r_kind;
    logic                       r_call;
    logic                       r_ret;
    logic                       r_taken;
    logic                       r_last;
    logic [fbg_pkg::OFS_W-1:0]  r_offset;
    logic                       r_started;

    logic                       w_take;
    logic [SW-1:0]              w_size;
    logic [SW-1:0]              w_next_size;
    logic                       w_started;
    logic [SW-1:0]              w_bytes_base;
    logic [SW-1:0]              w_bytes_new;
    logic                       w_jump;
    logic                       w_last;
    logic [31:0]                w_delta;
    logic [fbg_pkg::OFS_W-1:0]  w_offset;

    assign o_pop  = !r_out_valid || o_out.ready;
    assign w_take = i_valid && o_pop;

    assign w_size      = i_pre.compressed ? SW'(2) : SW'(4);
    assign w_next_size = i_pre.next_compressed ? SW'(2) : SW'(4);

    assign w_started = !r_have_block || r_force_new || i_pre.discontinuous
                       || (SW'(r_bytes) + w_size > LIMIT_BYTES)
                       || (r_instrs >= LIMIT_INSTRS);

    assign w_bytes_base = w_started ? '0 : SW'(r_bytes);
    assign w_bytes_new  = w_bytes_base + w_size;
    assign w_jump       = (i_pre.branch_kind == fbg_pkg::KIND_JAL)
                          || (i_pre.branch_kind == fbg_pkg::KIND_JALR);
    assign w_last       = i_pre.predicted_taken || w_jump
                          || (w_bytes_new + w_next_size > LIMIT_BYTES);

    assign w_delta  = i_pre.pc - r_start_pc;
    assign w_offset = (w_started || (i_pre.pc < r_start_pc)) ? '0
                      : w_delta[fbg_pkg::OFS_W:1];

    always_comb begin
        n_block_id = r_block_id;
        n_wrap     = r_wrap;
        if (w_started && r_have_block) begin
            if (r_block_id >= LAST_ID) begin
                n_block_id = '0;
                n_wrap     = !r_wrap;
            end else begin
                n_block_id = r_block_id + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_block <= 1'b0;
            r_force_new  <= 1'b0;
            r_block_id   <= '0;
            r_wrap       <= 1'b0;
            r_bytes      <= '0;
            r_instrs     <= '0;
            r_start_pc   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_take) begin
                r_have_block <= 1'b1;
                r_force_new  <= w_jump || i_pre.predicted_taken;
                r_block_id   <= n_block_id;
                r_wrap       <= n_wrap;
                r_bytes      <= w_bytes_new[BW-1:0];
                r_instrs     <= (w_started ? '0 : r_instrs) + 1'b1;
                if (w_started) begin
                    r_start_pc <= i_pre.pc;
                end
            end
            if (o_pop) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_compressed <= i_pre.compressed;
            r_kind       <= i_pre.branch_kind;
            r_call       <= i_pre.call_flag;
            r_ret        <= i_pre.return_flag;
            r_taken      <= i_pre.predicted_taken;
            r_last       <= w_last;
            r_offset     <= w_offset;
            r_started    <= w_started;
        end
    end

    logic [fbg_pkg::ID_W-1:0] r_out_id;
    logic                     r_out_wrap;

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_id   <= n_block_id;
            r_out_wrap <= n_wrap;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.compressed      = r_compressed;
    assign o_out.branch_kind     = r_kind;
    assign o_out.call_flag       = r_call;
    assign o_out.return_flag     = r_ret;
    assign o_out.predicted_taken = r_taken;
    assign o_out.last_in_block   = r_last;
    assign o_out.block_id        = r_out_id;
    assign o_out.block_wrap      = r_out_wrap;
    assign o_out.halfword_offset = r_offset;
    assign o_out.block_started   = r_started;

endmodule

// ----- rtl/fetch_block_grouper.sv -----
// Fetch block grouper top level: predecode front, two-entry queue, grouping back end.
// An accepted transfer is written into the queue, then loads the result register when popped.
// Throughput: one instruction per cycle when not stalled; block state updates once per item.
// The front stalls only when the two-entry queue is full; the back only on result backpressure.
// Reset: synchronous, active low; clears block state, queue pointers and result valid.
module fetch_block_grouper #(
    parameter int BLOCK_BYTES      = 32,
    parameter int MAX_BLOCK_INSTRS = 16,
    parameter int ID_COUNT         = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fbg_in_if.sink      i_in,
    fbg_out_if.source   o_out
);

    fbg_pkg::t_pre w_front_pre;
    fbg_pkg::t_pre w_queue_pre;
    logic          w_push;
    logic          w_full;
    logic          w_queue_valid;
    logic          w_pop;

    fbg_front u_front (
        .i_valid              (i_in.valid),
        .i_instr_pc           (i_in.instr_pc),
        .i_instr_word         (i_in.instr_word),
        .i_following_pc       (i_in.following_pc),
        .i_following_low_bits (i_in.following_low_bits),
        .i_discontinuous      (i_in.discontinuous),
        .i_queue_full         (w_full),
        .o_ready              (i_in.ready),
        .o_push               (w_push),
        .o_pre                (w_front_pre)
    );

    fbg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_pre),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_queue_valid),
        .o_data  (w_queue_pre)
    );

    fbg_back #(
        .BLOCK_BYTES      (BLOCK_BYTES),
        .MAX_BLOCK_INSTRS (MAX_BLOCK_INSTRS),
        .ID_COUNT         (ID_COUNT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_queue_valid),
        .i_pre   (w_queue_pre),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
